// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SMES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SMES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checks what the ports show in the cycle after a reset edge.
`define SMES_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// File: src/smes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smes_pkg;

   localparam int ROW_W       = 12;
   localparam int COL_W       = 12;
   localparam int REG_W       = 13;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_IDX_W = 4;

   localparam logic [REG_W-1:0] DIM_RESET = 13'd4096;

   typedef enum logic {
      OP_READ   = 1'b0,
      OP_MODIFY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_GROUP,
      S_SELECT,
      S_READ,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic match_en;
      logic group_en;
      logic select_en;
      logic read_en;
      logic update_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

   // Index of the lowest set bit in one group; zero when none is set.
   function automatic logic [GROUP_IDX_W-1:0] lowest_set(input logic [GROUP_SIZE-1:0] bits);
      logic [GROUP_IDX_W-1:0] idx;
      idx = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
         if (bits[k]) begin
            idx = GROUP_IDX_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: src/smes_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smes_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                             valid;
   logic                             ready;
   smes_pkg::opcode_type             opcode;
   logic [smes_pkg::ROW_W-1:0]       row_index;
   logic [smes_pkg::COL_W-1:0]       column_index;
   logic signed [VALUE_BITS-1:0]     write_value;

   modport source (output valid, opcode, row_index, column_index, write_value, input ready);
   modport sink   (input valid, opcode, row_index, column_index, write_value, output ready);
endinterface

`default_nettype wire

// File: src/smes_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smes_rsp_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] result_value;
   smes_pkg::status_type         status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

// File: src/sparse_matrix_entry_store.sv
// A response becomes valid once its request has passed the match, group, select,
// read and update states; update waits while the response register is held.
// A new request is accepted only in the idle state, after the previous one has
// finished its update. Reset (synchronous, active high) clears all slots, the
// entry count and the response valid flag, and sets both dimension registers to 4096.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_entry_store #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIM     = 4096,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   smes_req_if.sink                        req_ch,
   smes_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_we,
   input  wire smes_pkg::csr_index_type    csr_index,
   input  wire logic [smes_pkg::REG_W-1:0] csr_wdata
);

   // The controller walks each request through a fixed sequence: the latched
   // position is compared against every stored key at once, the match and
   // free-slot vectors are reduced in groups of sixteen, the lowest group is
   // chosen, the value memory is read at the matching slot, and finally the
   // table is updated and the response register is loaded, once it is free.
   smes_pkg::ctrl_cmd_type  cmd;
   smes_pkg::dp_status_type sts;

   smes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the keys in flops, the values in a memory and the
   // response in a register of its own, so a new request can be accepted
   // while the previous response still waits for the consumer.
   smes_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DIM     (MAX_DIM),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_ch.opcode),
      .req_row_index    (req_ch.row_index),
      .req_column_index (req_ch.column_index),
      .req_write_value  (req_ch.write_value),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_status       (rsp_ch.status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

`default_nettype wire

// File: src/smes_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smes_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire smes_pkg::dp_status_type sts,
   output smes_pkg::ctrl_cmd_type       cmd
);

   smes_pkg::state_type state_ff;
   smes_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smes_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         smes_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = smes_pkg::S_MATCH;
            end
         end
         smes_pkg::S_MATCH: begin
            cmd.match_en = 1'b1;
            state_in     = smes_pkg::S_GROUP;
         end
         smes_pkg::S_GROUP: begin
            cmd.group_en = 1'b1;
            state_in     = smes_pkg::S_SELECT;
         end
         smes_pkg::S_SELECT: begin
            cmd.select_en = 1'b1;
            state_in      = smes_pkg::S_READ;
         end
         smes_pkg::S_READ: begin
            cmd.read_en = 1'b1;
            state_in    = smes_pkg::S_UPDATE;
         end
         smes_pkg::S_UPDATE: begin
            // Hold until the response register is free.
            if (!sts.rsp_busy) begin
               cmd.update_en = 1'b1;
               state_in      = smes_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smes_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/smes_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module smes_dp #(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DIM     = 4096,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire smes_pkg::ctrl_cmd_type        cmd,
   output smes_pkg::dp_status_type            sts,
   input  wire smes_pkg::opcode_type          req_opcode,
   input  wire logic [smes_pkg::ROW_W-1:0]    req_row_index,
   input  wire logic [smes_pkg::COL_W-1:0]    req_column_index,
   input  wire logic [VALUE_BITS-1:0]         req_write_value,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [VALUE_BITS-1:0]              rsp_result_value,
   output smes_pkg::status_type               rsp_status,
   input  wire logic                          csr_we,
   input  wire smes_pkg::csr_index_type       csr_index,
   input  wire logic [smes_pkg::REG_W-1:0]    csr_wdata
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int GRP    = smes_pkg::GROUP_SIZE;
   localparam int GIW    = smes_pkg::GROUP_IDX_W;
   localparam int NG     = (MAX_ENTRIES + GRP - 1) / GRP;
   localparam int PAD    = NG * GRP;
   localparam int NG_W   = (NG > 1) ? $clog2(NG) : 1;
   localparam int FULL_W = NG_W + GIW;
   localparam int REG_W  = smes_pkg::REG_W;

   // Latched request.
   smes_pkg::opcode_type       op_ff;
   logic [smes_pkg::ROW_W-1:0] row_ff;
   logic [smes_pkg::COL_W-1:0] col_ff;
   logic [VALUE_BITS-1:0]      wval_ff;

   // Configuration.
   logic [REG_W-1:0] row_count_ff;
   logic [REG_W-1:0] column_count_ff;

   // Entry keys live in flops so that every slot is compared at once.
   logic [smes_pkg::ROW_W-1:0] key_row_ff [MAX_ENTRIES];
   logic [smes_pkg::COL_W-1:0] key_col_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]     valid_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [VALUE_BITS-1:0]      value_mem [MAX_ENTRIES];
   logic [VALUE_BITS-1:0]      rd_data_ff;

   // Search pipeline.
   logic [PAD-1:0]  match_ff, match_in;
   logic [PAD-1:0]  free_ff, free_in;
   logic            oor_ff, oor_in;
   logic [NG-1:0]   grp_hit_ff, grp_hit_in;
   logic [NG-1:0]   grp_free_ff, grp_free_in;
   logic [GIW-1:0]  grp_hit_idx_ff [NG];
   logic [GIW-1:0]  grp_hit_idx_in [NG];
   logic [GIW-1:0]  grp_free_idx_ff [NG];
   logic [GIW-1:0]  grp_free_idx_in [NG];
   logic            hit_ff, hit_in;
   logic [FULL_W-1:0] hit_full, free_full;
   logic [IDX_W-1:0]  hit_idx_ff, free_idx_ff;

   // Update decisions.
   logic                  wzero;
   logic                  full;
   logic                  mem_we;
   logic                  set_valid;
   logic                  clr_valid;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0] rsp_value_in;
   smes_pkg::status_type  rsp_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   smes_pkg::status_type  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_opcode;
         row_ff  <= req_row_index;
         col_ff  <= req_column_index;
         wval_ff <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= smes_pkg::DIM_RESET;
         column_count_ff <= smes_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            smes_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_wdata;
            smes_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Stage 1: compare every slot and check the position against the dimensions.
   always_comb begin
      match_in = '0;
      free_in  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_row_ff[i] == row_ff) && (key_col_ff[i] == col_ff);
         free_in[i]  = !valid_ff[i];
      end
      oor_in = (REG_W'(row_ff) >= row_count_ff) || (REG_W'(col_ff) >= column_count_ff)
               || (32'(row_ff) >= 32'(MAX_DIM)) || (32'(col_ff) >= 32'(MAX_DIM));
   end

   // Stage 2: reduce within groups.
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_hit_in[g]      = |match_ff[g*GRP +: GRP];
         grp_free_in[g]     = |free_ff[g*GRP +: GRP];
         grp_hit_idx_in[g]  = smes_pkg::lowest_set(match_ff[g*GRP +: GRP]);
         grp_free_idx_in[g] = smes_pkg::lowest_set(free_ff[g*GRP +: GRP]);
      end
   end

   // Stage 3: pick the lowest group.
   always_comb begin
      hit_in    = 1'b0;
      hit_full  = '0;
      free_full = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            hit_in   = 1'b1;
            hit_full = {NG_W'(g), grp_hit_idx_ff[g]};
         end
         if (grp_free_ff[g]) begin
            free_full = {NG_W'(g), grp_free_idx_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match_en) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         oor_ff   <= oor_in;
      end
      if (cmd.group_en) begin
         grp_hit_ff      <= grp_hit_in;
         grp_free_ff     <= grp_free_in;
         grp_hit_idx_ff  <= grp_hit_idx_in;
         grp_free_idx_ff <= grp_free_idx_in;
      end
      if (cmd.select_en) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_full[IDX_W-1:0];
         free_idx_ff <= free_full[IDX_W-1:0];
      end
   end

   always_comb begin
      wzero         = (wval_ff == '0);
      full          = (count_ff == CNT_W'(MAX_ENTRIES));
      mem_we        = 1'b0;
      set_valid     = 1'b0;
      clr_valid     = 1'b0;
      wr_addr       = hit_idx_ff;
      rsp_value_in  = hit_ff ? rd_data_ff : '0;
      rsp_status_in = smes_pkg::ST_OK;
      if (oor_ff) begin
         rsp_value_in  = '0;
         rsp_status_in = smes_pkg::ST_RANGE;
      end else if (op_ff == smes_pkg::OP_MODIFY) begin
         if (hit_ff) begin
            if (wzero) begin
               clr_valid = 1'b1;
            end else begin
               mem_we = 1'b1;
            end
         end else if (!wzero) begin
            if (full) begin
               rsp_status_in = smes_pkg::ST_FULL;
            end else begin
               mem_we    = 1'b1;
               set_valid = 1'b1;
               wr_addr   = free_idx_ff;
            end
         end
      end
      count_in = count_ff;
      if (cmd.update_en && set_valid) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.update_en && clr_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.update_en && set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (cmd.update_en && clr_valid) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en && set_valid) begin
         key_row_ff[wr_addr] <= row_ff;
         key_col_ff[wr_addr] <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en && mem_we) begin
         value_mem[wr_addr] <= wval_ff;
      end
      if (cmd.read_en) begin
         rd_data_ff <= value_mem[hit_idx_ff];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign sts.rsp_busy     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// File: src/smes_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smes_checker #(
   parameter int VALUE_BITS = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [VALUE_BITS-1:0] rsp_result_value,
   input wire logic [1:0]            rsp_status
);

   // Only one request is in flight at a time.
   `SMES_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in flight")

   `SMES_ASSERT_IMPLY(a_range_zero, clock, reset, rsp_valid && (rsp_status == smes_pkg::ST_RANGE), rsp_result_value == '0, "out-of-range response carries a value")

   `SMES_ASSERT_IMPLY(a_full_zero, clock, reset, rsp_valid && (rsp_status == smes_pkg::ST_FULL), rsp_result_value == '0, "table-full response carries a value")

   `SMES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status), "stalled response changed")

   `SMES_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind sparse_matrix_entry_store smes_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import smes_pkg::*;

   // Sizes of the design under test at its default parameters.
   localparam int MAX_ENTRIES = 256;
   localparam int MAX_DIM = 4096;
   localparam int VALUE_BITS = 32;

   // Quiet cycles allowed before the run is declared hung. The slowest
   // legal stretch is a long sender gap, the access latency and a long
   // receiver stall back to back, plus the pause around a register write.
   localparam int WATCHDOG_LIMIT = 3000;

   // Cycles left after the last response before registers are rewritten.
   localparam int SETTLE_CYCLES = 8;

   // At most this many mismatch lines are printed; all are counted.
   localparam int PRINT_CAP = 200;

   // One request as the sender sees it. A request marked drain_first is
   // held back until every response already owed has come back.
   typedef struct {
      opcode_type op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic signed [VALUE_BITS-1:0] value;
      bit drain_first;
   } access_type;

   // The response that a request must produce.
   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      status_type status;
   } access_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [REG_W-1:0] csr_wdata;

   smes_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   smes_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

   sparse_matrix_entry_store #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_DIM(MAX_DIM),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Requests waiting to be sent, and responses owed by the block, oldest
   // first.
   access_type access_queue[$];
   access_result_type awaited_results[$];

   // The testbench's own copy of the entry table and dimension registers.
   logic [ROW_W-1:0] slot_row[MAX_ENTRIES];
   logic [COL_W-1:0] slot_col[MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0] slot_val[MAX_ENTRIES];
   bit slot_live[MAX_ENTRIES];
   int live_count = 0;
   logic [REG_W-1:0] row_limit = DIM_RESET;
   logic [REG_W-1:0] col_limit = DIM_RESET;

   int error_count = 0;
   int tx_gap = 0;
   int rx_hold = 0;
   int quiet_cycles = 0;

   // When set, the matching side of the handshake never idles.
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;

   // Columns used by the table-filling phase, so that later requests can
   // hit those entries again.
   logic [COL_W-1:0] fill_col[300];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 0;
      end else if (sel < 85) begin
         return $urandom_range(1, 3);
      end else if (sel < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Predicts the response to one request and applies its effect on the
   // table. A position outside the capped dimensions leaves the table alone;
   // an insert goes to the lowest free slot, and a full table refuses it.
   function automatic access_result_type apply_access(input access_type a);
      access_result_type res;
      int rows;
      int cols;
      int hit;
      int free_k;
      res.value = '0;
      res.status = ST_OK;
      rows = (row_limit > MAX_DIM) ? MAX_DIM : row_limit;
      cols = (col_limit > MAX_DIM) ? MAX_DIM : col_limit;
      if (a.row >= rows || a.col >= cols) begin
         res.status = ST_RANGE;
         return res;
      end
      hit = -1;
      free_k = -1;
      for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
         if (slot_live[k] && slot_row[k] == a.row && slot_col[k] == a.col) begin
            hit = k;
         end
         if (!slot_live[k]) begin
            free_k = k;
         end
      end
      if (hit >= 0) begin
         res.value = slot_val[hit];
      end
      if (a.op == OP_MODIFY) begin
         if (hit >= 0) begin
            if (a.value == 0) begin
               slot_live[hit] = 1'b0;
               live_count--;
            end else begin
               slot_val[hit] = a.value;
            end
         end else if (a.value != 0) begin
            if (free_k >= 0) begin
               slot_row[free_k] = a.row;
               slot_col[free_k] = a.col;
               slot_val[free_k] = a.value;
               slot_live[free_k] = 1'b1;
               live_count++;
            end else begin
               res.status = ST_FULL;
            end
         end
      end
      return res;
   endfunction

   function automatic void queue_access(input opcode_type op, input int row, input int col,
                                        input logic [VALUE_BITS-1:0] value,
                                        input bit drain_first);
      access_type a;
      a.op = op;
      a.row = ROW_W'(row);
      a.col = COL_W'(col);
      a.value = value;
      a.drain_first = drain_first;
      access_queue.push_back(a);
   endfunction

   // Index near the interesting spots of a dimension: the low corner, the
   // last valid position, just past the end, or anywhere at all.
   function automatic int pick_index(input int dim);
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         v = $urandom_range(0, 3);
      end else if (sel < 55) begin
         v = dim - 1 - $urandom_range(0, 1);
      end else if (sel < 70) begin
         v = dim + $urandom_range(0, 2);
      end else begin
         v = $urandom_range(0, 4095);
      end
      if (v < 0) begin
         v = 0;
      end
      if (v > 4095) begin
         v = 4095;
      end
      return v;
   endfunction

   // Zero often, since it removes entries; the sign extremes now and then.
   function automatic logic [VALUE_BITS-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         return '0;
      end else if (sel < 34) begin
         return 32'h7FFF_FFFF;
      end else if (sel < 38) begin
         return 32'h8000_0000;
      end else if (sel < 42) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_nonzero();
      logic [VALUE_BITS-1:0] v;
      v = $urandom;
      if (v == 0) begin
         v = 1;
      end
      return v;
   endfunction

   // A run of random requests. A few of them wait for the block to drain
   // first, so that the sender also pauses in the middle of a phase.
   function automatic void queue_random(input int count, input int row_dim, input int col_dim);
      opcode_type op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 1) == 1) ? OP_MODIFY : OP_READ;
         queue_access(op, pick_index(row_dim), pick_index(col_dim), pick_value(),
                      $urandom_range(0, 99) < 3);
      end
   endfunction

   // Waits until every request has gone out and every response has come
   // back, then lets the block settle. The check is made a little after
   // the edge, once the driver's updates of that edge are visible.
   task automatic settle_idle();
      do begin
         @(posedge clock);
         #1;
      end while (access_queue.size() > 0 || req_ch.valid || awaited_results.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one dimension register. The block is idle here, so the local
   // copy can follow at once.
   task automatic write_csr(input csr_index_type idx, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ROW_COUNT) begin
         row_limit = value;
      end else begin
         col_limit = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_dims(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols);
      settle_idle();
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_COLUMN_COUNT, cols);
   endtask

   // Request driver. When a request is taken, its response is predicted
   // right away; then the next request is put up after a random gap. The
   // valid line is held while the block is not ready.
   always @(posedge clock) begin
      access_type nxt;
      access_type taken;
      if (reset) begin
         req_ch.valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.op = req_ch.opcode;
            taken.row = req_ch.row_index;
            taken.col = req_ch.column_index;
            taken.value = req_ch.write_value;
            taken.drain_first = 1'b0;
            awaited_results.push_back(apply_access(taken));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (access_queue.size() > 0 &&
                         !(access_queue[0].drain_first && awaited_results.size() > 0)) begin
               nxt = access_queue.pop_front();
               req_ch.opcode <= nxt.op;
               req_ch.row_index <= nxt.row;
               req_ch.column_index <= nxt.col;
               req_ch.write_value <= nxt.value;
               req_ch.valid <= 1'b1;
               tx_gap <= tx_burst ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each response taken is checked against the oldest
   // prediction. The ready line is dropped for random stretches.
   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_hold <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.result_value !== want.value) begin
                  report_mismatch($sformatf("result_value %0d, predicted %0d",
                                            rsp_ch.result_value, want.value));
               end
               if (rsp_ch.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_ch.status, want.status));
               end
            end
         end
         if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
            rx_hold <= pick_gap();
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: any request or response taken counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int sel;
      int k;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_READ;
      req_ch.row_index = '0;
      req_ch.column_index = '0;
      req_ch.write_value = '0;
      rsp_ch.ready = 1'b0;
      for (int n = 0; n < MAX_ENTRIES; n++) begin
         slot_live[n] = 1'b0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset dimensions: reads of an empty position,
      // insert, update, removal, removal of an absent entry, and values at
      // both sign extremes in the four corners.
      queue_access(OP_READ, 0, 0, 32'h1234_5678, 1'b0);
      queue_access(OP_MODIFY, 0, 0, 32'h7FFF_FFFF, 1'b0);
      queue_access(OP_READ, 0, 0, '0, 1'b0);
      queue_access(OP_MODIFY, 0, 0, 32'h8000_0000, 1'b0);
      queue_access(OP_MODIFY, 4095, 4095, 32'hFFFF_FFFF, 1'b0);
      queue_access(OP_READ, 4095, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 4095, 4095, '0, 1'b0);
      queue_access(OP_READ, 4095, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 4095, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 0, 4095, 32'h0000_0001, 1'b0);
      queue_access(OP_MODIFY, 4095, 0, 32'h5555_5555, 1'b0);
      queue_access(OP_READ, 0, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 4095, 0, 32'hAAAA_AAAA, 1'b1);

      // A single row: anything past row 0 is out of range and changes
      // nothing, while row 0 still reaches its entries.
      set_dims(13'd1, 13'd4096);
      queue_access(OP_READ, 1, 0, '0, 1'b0);
      queue_access(OP_MODIFY, 1, 5, 32'h0000_0007, 1'b0);
      queue_access(OP_READ, 0, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 0, 0, '0, 1'b0);

      // A single column.
      set_dims(13'd4096, 13'd1);
      queue_access(OP_READ, 4095, 0, '0, 1'b0);
      queue_access(OP_READ, 0, 1, '0, 1'b0);

      // Zero dimensions put every position out of range.
      set_dims(13'd0, 13'd0);
      queue_access(OP_READ, 0, 0, '0, 1'b0);
      queue_access(OP_MODIFY, 0, 0, 32'h0000_0003, 1'b0);

      // Register values above the matrix size are capped at 4096.
      set_dims(13'h1FFF, 13'h1FFF);
      queue_access(OP_READ, 4095, 4095, '0, 1'b0);
      queue_access(OP_MODIFY, 4095, 4095, 32'h0000_0009, 1'b0);

      // Random mix at full size, both sides idling at random.
      set_dims(13'd4096, 13'd4096);
      queue_random(150, 4096, 4096);

      // Small random dimensions with no idling at all.
      set_dims(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
      tx_burst = 1'b1;
      rx_burst = 1'b1;
      queue_random(60, row_limit, col_limit);
      set_dims(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
      queue_random(60, row_limit, col_limit);

      // Fill the table well past its capacity, so that the later inserts
      // are refused, then mix reads, removals and inserts that reuse the
      // freed slots. The sender runs flat out; the receiver stalls.
      set_dims(13'd4096, 13'd4096);
      tx_burst = 1'b1;
      rx_burst = 1'b0;
      for (int n = 0; n < 300; n++) begin
         fill_col[n] = COL_W'($urandom_range(0, 4095));
         queue_access(OP_MODIFY, 1024 + n, fill_col[n], pick_nonzero(),
                      $urandom_range(0, 99) < 2);
      end
      for (int n = 0; n < 60; n++) begin
         sel = $urandom_range(0, 99);
         k = $urandom_range(0, 299);
         if (sel < 40) begin
            queue_access(OP_READ, 1024 + k, fill_col[k], pick_value(), 1'b0);
         end else if (sel < 70) begin
            queue_access(OP_MODIFY, 1024 + k, fill_col[k], pick_value(),
                         $urandom_range(0, 99) < 5);
         end else begin
            queue_access(OP_MODIFY, 2048 + n, $urandom_range(0, 4095), pick_nonzero(),
                         1'b0);
         end
      end

      // Narrow columns at full row count; the sender idles, the receiver
      // never stalls.
      set_dims(13'd4096, 13'($urandom_range(1, 8)));
      tx_burst = 1'b0;
      rx_burst = 1'b1;
      queue_random(40, row_limit, col_limit);

      settle_idle();
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
